// ----- design/binomial_option_pricer_macros.svh -----
// Assertion macros used by the checker file of the binomial option pricer.
`ifndef BINOMIAL_OPTION_PRICER_MACROS_SVH
`define BINOMIAL_OPTION_PRICER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BOP_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define BOP_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bop_pkg.sv -----
// Types, constants and helper functions of the binomial option pricer.
package bop_pkg;

	localparam int MAX_STEPS = 128;
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int LAT_DEPTH = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2;
	localparam int LAT_AW = $clog2(LAT_DEPTH);
	localparam int VR_DEPTH = MAX_STEPS + 1;
	localparam int VR_AW = $clog2(VR_DEPTH);
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam logic [DATA_W-1:0] ONE_Q31 = 32'h8000_0000;

	// Configuration register indexes.
	localparam logic [1:0] REG_UP_FACTOR = 2'd0;
	localparam logic [1:0] REG_DOWN_FACTOR = 2'd1;
	localparam logic [1:0] REG_UP_PROB = 2'd2;
	localparam logic [1:0] REG_DISCOUNT = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROOT,
		S_BLD_RD,
		S_BLD_MUL,
		S_BLD_WR,
		S_LEAF_RD,
		S_LEAF_WR,
		S_BK_RD,
		S_BK_UP,
		S_BK_DN,
		S_BK_SUM,
		S_BK_DISC,
		S_BK_WR,
		S_FIN_RD,
		S_FIN
	} bop_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_BUILD_MUL,
		OP_BUILD_WR,
		OP_LEAF_WR,
		OP_MUL_UP,
		OP_MUL_DN,
		OP_SUM,
		OP_DISC,
		OP_NODE_WR
	} bop_op_t;

	typedef struct packed {
		logic load;
		logic root_wr;
		logic lat_re;
		logic [LAT_AW-1:0] lat_raddr;
		logic lat_we;
		logic [LAT_AW-1:0] lat_waddr;
		logic vr_re;
		logic [VR_AW-1:0] vr_raddr;
		logic vr_we;
		logic [VR_AW-1:0] vr_waddr;
		bop_op_t op;
		logic use_down;
		logic last_node;
		logic fin;
	} bop_cmd_t;

	typedef struct packed {
		logic [STEP_W-1:0] steps;
	} bop_status_t;

	// Exercise payoff of one asset value.
	function automatic logic [DATA_W-1:0] payoff(input logic [DATA_W-1:0] s,
			input logic [DATA_W-1:0] k, input logic put);
		logic [DATA_W-1:0] r;
		if (put) begin
			r = (k > s) ? (k - s) : '0;
		end else begin
			r = (s > k) ? (s - k) : '0;
		end
		return r;
	endfunction

endpackage

// ----- design/bop_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and a read port whose data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bop_dp.sv -----
// Datapath of the binomial option pricer: registers, multiplier and lattice memories.
module bop_dp import bop_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic [31:0]       spot_price,
	input  logic [31:0]       strike_price,
	input  logic [7:0]        step_count,
	input  logic              is_put,
	input  logic              american_style,
	input  bop_cmd_t          cmd,
	output bop_status_t       status,
	output logic [31:0]       option_price,
	output logic              exercise_at_root,
	output logic              saturated
);

	logic [DATA_W-1:0] up_q, down_q, prob_q, disc_cfg_q;
	logic [DATA_W-1:0] spot_q, strike_q, q_q, qc_q, disc_q;
	logic [STEP_W-1:0] steps_q;
	logic put_q, amer_q, sat_q, stop_q;
	logic [PROD_W-1:0] prod_q;
	logic [DATA_W-1:0] acc_q, pay_q;
	logic [DATA_W-1:0] lat_rdata, vr_rdata, lat_wdata, vr_wdata;
	logic [DATA_W-1:0] build_val, cont, node_val, leaf_pay, q_eff, disc_eff;
	logic node_stop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= 32'h4000_0000;
			down_q <= 32'h4000_0000;
			prob_q <= 32'h4000_0000;
			disc_cfg_q <= ONE_Q31;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_UP_FACTOR: up_q <= cfg_data;
				REG_DOWN_FACTOR: down_q <= cfg_data;
				REG_UP_PROB: prob_q <= cfg_data;
				REG_DISCOUNT: disc_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories for the asset lattice and the working value row.
	bop_ram #(.WIDTH(DATA_W), .DEPTH(LAT_DEPTH)) u_lat (
		.clk(clk), .we(cmd.lat_we), .waddr(cmd.lat_waddr), .wdata(lat_wdata),
		.re(cmd.lat_re), .raddr(cmd.lat_raddr), .rdata(lat_rdata)
	);

	bop_ram #(.WIDTH(DATA_W), .DEPTH(VR_DEPTH)) u_vr (
		.clk(clk), .we(cmd.vr_we), .waddr(cmd.vr_waddr), .wdata(vr_wdata),
		.re(cmd.vr_re), .raddr(cmd.vr_raddr), .rdata(vr_rdata)
	);

	// Clamped probability and discount, and write data selection.
	always_comb begin
		q_eff = (prob_q > ONE_Q31) ? ONE_Q31 : prob_q;
		disc_eff = (disc_cfg_q > ONE_Q31) ? ONE_Q31 : disc_cfg_q;
		build_val = (prod_q[PROD_W-1:PROD_W-2] != 2'b00) ? '1 : prod_q[61:30];
		cont = prod_q[62:31];
		leaf_pay = payoff(lat_rdata, strike_q, put_q);
		node_stop = 1'b0;
		node_val = cont;
		if (amer_q) begin
			if (cont > pay_q) begin
				node_val = cont;
			end else begin
				node_val = pay_q;
				node_stop = (pay_q != '0);
			end
		end
		lat_wdata = cmd.root_wr ? spot_q : build_val;
		vr_wdata = (cmd.op == OP_LEAF_WR) ? leaf_pay : node_val;
	end

	// Item registers and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (cmd.load) begin
			sat_q <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			if (cmd.op == OP_BUILD_WR && prod_q[PROD_W-1:PROD_W-2] != 2'b00) begin
				sat_q <= 1'b1;
			end
			if (cmd.op == OP_LEAF_WR && cmd.last_node) begin
				stop_q <= amer_q && (leaf_pay != '0);
			end
			if (cmd.op == OP_NODE_WR && cmd.last_node) begin
				stop_q <= amer_q && node_stop;
			end
		end
	end

	// Operand capture and the shared multiplier.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			spot_q <= spot_price;
			strike_q <= strike_price;
			steps_q <= (step_count > 8'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
				: STEP_W'(step_count);
			put_q <= is_put;
			amer_q <= american_style;
			q_q <= q_eff;
			qc_q <= ONE_Q31 - q_eff;
			disc_q <= disc_eff;
		end
		case (cmd.op)
			OP_BUILD_MUL: prod_q <= lat_rdata * (cmd.use_down ? down_q : up_q);
			OP_MUL_UP: prod_q <= vr_rdata * q_q;
			OP_MUL_DN: begin
				acc_q <= prod_q[62:31];
				prod_q <= vr_rdata * qc_q;
			end
			OP_SUM: begin
				acc_q <= acc_q + prod_q[62:31];
				pay_q <= payoff(lat_rdata, strike_q, put_q);
			end
			OP_DISC: prod_q <= acc_q * disc_q;
			default: ;
		endcase
		if (cmd.fin) begin
			option_price <= vr_rdata;
			exercise_at_root <= stop_q;
			saturated <= sat_q;
		end
	end

	assign status.steps = steps_q;

endmodule

// ----- design/bop_ctrl.sv -----
// Controller of the binomial option pricer: state machine and lattice counters.
module bop_ctrl import bop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  bop_status_t status,
	output bop_cmd_t    cmd
);

	bop_state_t state_q, state_d;
	logic [STEP_W-1:0] n_q, j_q;
	logic [LAT_AW-1:0] pbase_q, cbase_q;
	logic out_valid_q;
	logic row_end, can_fin;

	assign row_end = (j_q == n_q);
	assign can_fin = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin
				state_d = S_ROOT;
			end
			S_ROOT: state_d = (status.steps == '0) ? S_LEAF_RD : S_BLD_RD;
			S_BLD_RD: state_d = S_BLD_MUL;
			S_BLD_MUL: state_d = S_BLD_WR;
			S_BLD_WR: begin
				if (row_end && n_q == status.steps) begin
					state_d = S_LEAF_RD;
				end else begin
					state_d = S_BLD_RD;
				end
			end
			S_LEAF_RD: state_d = S_LEAF_WR;
			S_LEAF_WR: begin
				if (j_q != status.steps) begin
					state_d = S_LEAF_RD;
				end else if (status.steps == '0) begin
					state_d = S_FIN_RD;
				end else begin
					state_d = S_BK_RD;
				end
			end
			S_BK_RD: state_d = S_BK_UP;
			S_BK_UP: state_d = S_BK_DN;
			S_BK_DN: state_d = S_BK_SUM;
			S_BK_SUM: state_d = S_BK_DISC;
			S_BK_DISC: state_d = S_BK_WR;
			S_BK_WR: state_d = (row_end && n_q == '0) ? S_FIN_RD : S_BK_RD;
			S_FIN_RD: state_d = S_FIN;
			S_FIN: if (can_fin) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_ROOT: begin
				cmd.root_wr = 1'b1;
				cmd.lat_we = 1'b1;
				cmd.lat_waddr = '0;
			end
			S_BLD_RD: begin
				cmd.lat_re = 1'b1;
				cmd.lat_raddr = (j_q == '0) ? pbase_q
					: pbase_q + LAT_AW'(j_q) - LAT_AW'(1);
			end
			S_BLD_MUL: begin
				cmd.op = OP_BUILD_MUL;
				cmd.use_down = (j_q == '0);
			end
			S_BLD_WR: begin
				cmd.op = OP_BUILD_WR;
				cmd.lat_we = 1'b1;
				cmd.lat_waddr = cbase_q + LAT_AW'(j_q);
			end
			S_LEAF_RD: begin
				cmd.lat_re = 1'b1;
				cmd.lat_raddr = cbase_q + LAT_AW'(j_q);
			end
			S_LEAF_WR: begin
				cmd.op = OP_LEAF_WR;
				cmd.vr_we = 1'b1;
				cmd.vr_waddr = VR_AW'(j_q);
				cmd.last_node = (status.steps == '0);
			end
			S_BK_RD: begin
				cmd.vr_re = 1'b1;
				cmd.vr_raddr = VR_AW'(j_q) + VR_AW'(1);
			end
			S_BK_UP: begin
				cmd.op = OP_MUL_UP;
				cmd.vr_re = 1'b1;
				cmd.vr_raddr = VR_AW'(j_q);
			end
			S_BK_DN: begin
				cmd.op = OP_MUL_DN;
				cmd.lat_re = 1'b1;
				cmd.lat_raddr = cbase_q + LAT_AW'(j_q);
			end
			S_BK_SUM: cmd.op = OP_SUM;
			S_BK_DISC: cmd.op = OP_DISC;
			S_BK_WR: begin
				cmd.op = OP_NODE_WR;
				cmd.vr_we = 1'b1;
				cmd.vr_waddr = VR_AW'(j_q);
				cmd.last_node = (n_q == '0);
			end
			S_FIN_RD: begin
				cmd.vr_re = 1'b1;
				cmd.vr_raddr = '0;
			end
			S_FIN: cmd.fin = can_fin;
			default: ;
		endcase
	end

	// State, lattice counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			j_q <= '0;
			pbase_q <= '0;
			cbase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_ROOT: begin
					j_q <= '0;
					pbase_q <= '0;
					if (status.steps == '0) begin
						n_q <= '0;
						cbase_q <= '0;
					end else begin
						n_q <= STEP_W'(1);
						cbase_q <= LAT_AW'(1);
					end
				end
				S_BLD_WR: begin
					if (!row_end) begin
						j_q <= j_q + STEP_W'(1);
					end else begin
						j_q <= '0;
						if (n_q != status.steps) begin
							n_q <= n_q + STEP_W'(1);
							pbase_q <= cbase_q;
							cbase_q <= cbase_q + LAT_AW'(n_q) + LAT_AW'(1);
						end
					end
				end
				S_LEAF_WR: begin
					if (j_q != status.steps) begin
						j_q <= j_q + STEP_W'(1);
					end else begin
						j_q <= '0;
						n_q <= status.steps - STEP_W'(1);
						cbase_q <= cbase_q - LAT_AW'(status.steps);
					end
				end
				S_BK_WR: begin
					if (!row_end) begin
						j_q <= j_q + STEP_W'(1);
					end else begin
						j_q <= '0;
						if (n_q != '0) begin
							n_q <= n_q - STEP_W'(1);
							cbase_q <= cbase_q - LAT_AW'(n_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- design/binomial_option_pricer.sv -----
// Top level of the binomial option pricer.
//
// Channel   Direction  Handshake            Beat
// input     in         in_valid / in_stall  one option: spot, strike, steps, put, style
// output    out        out_valid/out_stall  root price, root exercise flag, saturation
// config    in         cfg_write            one register write, no back-pressure
//
// An option occupies the block from the idle cycle that takes its beat until its result is
// written, and no new option is taken meanwhile; its run time is set by the one shared
// 32x32 multiplier and the single read port of each lattice memory.
// Reset clears the controller and configuration registers; the memories need none.
// A finished beat waits in the output register while the next option is taken;
// the last write of an item waits only while that register is still full and stalled.
module binomial_option_pricer import bop_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] spot_price,
	input  logic [31:0] strike_price,
	input  logic [7:0]  step_count,
	input  logic        is_put,
	input  logic        american_style,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] option_price,
	output logic        exercise_at_root,
	output logic        saturated
);

	bop_cmd_t cmd;
	bop_status_t status;

	bop_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	bop_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .spot_price(spot_price), .strike_price(strike_price),
		.step_count(step_count), .is_put(is_put), .american_style(american_style),
		.cmd(cmd), .status(status), .option_price(option_price),
		.exercise_at_root(exercise_at_root), .saturated(saturated)
	);

endmodule

// ----- design/bop_checker.sv -----
// Port-level checks of the binomial option pricer, bound to its top level.
`include "binomial_option_pricer_macros.svh"

module bop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] option_price,
	input logic        exercise_at_root
);

	// A stalled result beat stays offered and unchanged.
	`BOP_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
	`BOP_CHECK_NEXT(a_out_stable, out_valid && out_stall, $stable(option_price), "result changed")

	// An accepted option keeps the block busy in the following cycle.
	`BOP_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "taken while busy")

	// Early exercise at the root only ever returns a nonzero payoff.
	`BOP_CHECK(a_exer, out_valid |-> (!exercise_at_root || option_price != 32'd0), "zero price")

endmodule

bind binomial_option_pricer bop_checker u_bop_checker (.*);

// ----- bench/binomial_option_pricer_tb.sv -----
// Self-checking testbench for the binomial option pricer against a lattice predictor.
`timescale 1ns / 1ps

module binomial_option_pricer_tb;
	import bop_pkg::*;

	typedef struct {
		logic [31:0] spot;
		logic [31:0] strike;
		logic [7:0]  steps;
		logic        put;
		logic        amer;
	} option_t;

	typedef struct {
		logic [31:0] price;
		logic        exercise;
		logic        sat;
	} quote_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = REG_UP_FACTOR;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] spot_price = '0;
	logic [31:0] strike_price = '0;
	logic [7:0]  step_count = '0;
	logic        is_put = 1'b0;
	logic        american_style = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] option_price;
	logic        exercise_at_root;
	logic        saturated;

	// Mirror of the configuration registers.
	logic [31:0] cfg_u = 32'h4000_0000;
	logic [31:0] cfg_d = 32'h4000_0000;
	logic [31:0] cfg_q = 32'h4000_0000;
	logic [31:0] cfg_disc = 32'h8000_0000;

	option_t pending_options[$];
	quote_t  expected_quotes[$];
	int      mismatches = 0;
	int      in_gap = 0;
	int      out_hold = 0;
	bit      no_idle = 0;

	logic [31:0] asset_grid [0:MAX_STEPS][0:MAX_STEPS];
	logic [31:0] node_value [0:MAX_STEPS];

	binomial_option_pricer dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Scale a price by a Q2.30 factor, clipping at the maximum.
	function automatic logic [31:0] scale_price(input logic [31:0] p, input logic [31:0] f,
			inout logic sat);
		logic [63:0] prod;
		prod = ({32'b0, p} * {32'b0, f}) >> 30;
		if (prod > 64'hFFFF_FFFF) begin
			sat = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return prod[31:0];
	endfunction

	function automatic logic [31:0] frac_mul(input logic [31:0] x, input logic [31:0] f);
		logic [63:0] prod;
		prod = ({32'b0, x} * {32'b0, f}) >> 31;
		return prod[31:0];
	endfunction

	function automatic logic [31:0] exercise_pay(input logic [31:0] s, input logic [31:0] k,
			input logic put);
		if (put) return (k > s) ? k - s : 32'd0;
		return (s > k) ? s - k : 32'd0;
	endfunction

	// Price one option on the lattice under the current register settings.
	function automatic quote_t price_option(input option_t o);
		quote_t r;
		logic [31:0] q, qc, disc, sum, cont, pay;
		logic sat, stop, s;
		int n, j, lvl, steps;
		q = (cfg_q > ONE_Q31) ? ONE_Q31 : cfg_q;
		qc = ONE_Q31 - q;
		disc = (cfg_disc > ONE_Q31) ? ONE_Q31 : cfg_disc;
		sat = 1'b0;
		stop = 1'b0;
		steps = (o.steps > MAX_STEPS) ? MAX_STEPS : o.steps;
		asset_grid[0][0] = o.spot;
		for (n = 1; n <= steps; n++) begin
			asset_grid[n][0] = scale_price(asset_grid[n-1][0], cfg_d, sat);
			for (j = 1; j <= n; j++)
				asset_grid[n][j] = scale_price(asset_grid[n-1][j-1], cfg_u, sat);
		end
		for (j = 0; j <= steps; j++)
			node_value[j] = exercise_pay(asset_grid[steps][j], o.strike, o.put);
		if (steps == 0)
			stop = o.amer && (node_value[0] != 0);
		// Backward induction towards the root.
		for (n = steps; n > 0; n--) begin
			lvl = n - 1;
			for (j = 0; j <= lvl; j++) begin
				sum = frac_mul(node_value[j+1], q) + frac_mul(node_value[j], qc);
				cont = frac_mul(sum, disc);
				if (o.amer) begin
					pay = exercise_pay(asset_grid[lvl][j], o.strike, o.put);
					s = 1'b1;
					if (cont > pay) begin
						pay = cont;
						s = 1'b0;
					end else if (pay == 0) begin
						s = 1'b0;
					end
					node_value[j] = pay;
					if (lvl == 0) stop = s;
				end else begin
					node_value[j] = cont;
				end
			end
		end
		r.price = node_value[0];
		r.exercise = o.amer && stop;
		r.sat = sat;
		return r;
	endfunction

	function automatic int pick_gap();
		if (no_idle) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
		return $urandom_range(3, 60);
	endfunction

	// Input driver: presents queued options and records the expected quote on each beat.
	always @(posedge clk or negedge arst_n) begin
		option_t o;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				o.spot = spot_price;
				o.strike = strike_price;
				o.steps = step_count;
				o.put = is_put;
				o.amer = american_style;
				expected_quotes.push_back(price_option(o));
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_options.size() > 0) begin
					o = pending_options.pop_front();
					spot_price <= o.spot;
					strike_price <= o.strike;
					step_count <= o.steps;
					is_put <= o.put;
					american_style <= o.amer;
					in_valid <= 1'b1;
					in_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: random back-pressure and comparison of each beat.
	always @(posedge clk or negedge arst_n) begin
		quote_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_quotes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: price %h", option_price);
				end else begin
					e = expected_quotes.pop_front();
					if (e.price !== option_price || e.exercise !== exercise_at_root ||
							e.sat !== saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h/%b/%b got %h/%b/%b", e.price,
								e.exercise, e.sat, option_price, exercise_at_root, saturated);
					end
				end
			end
			if (out_hold > 0) begin
				out_hold <= out_hold - 1;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= ~out_stall;
				out_hold <= pick_gap();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic add_option(input logic [31:0] spot, input logic [31:0] strike,
			input logic [7:0] steps, input logic put, input logic amer);
		option_t o;
		o.spot = spot;
		o.strike = strike;
		o.steps = steps;
		o.put = put;
		o.amer = amer;
		pending_options.push_back(o);
	endtask

	task automatic add_random_option();
		logic [31:0] spot, strike;
		logic [7:0] steps;
		if ($urandom_range(0, 3) == 0) begin
			spot = $urandom;
			strike = $urandom;
		end else begin
			spot = $urandom_range(32'h0010_0000, 32'h0100_0000);
			strike = spot + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		end
		if ($urandom_range(0, 49) == 0) steps = 8'($urandom_range(129, 255));
		else if ($urandom_range(0, 9) == 0) steps = 8'($urandom_range(13, 40));
		else steps = 8'($urandom_range(0, 12));
		add_option(spot, strike, steps, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Waits until every queued option has been priced and checked.
	task automatic drain();
		do @(negedge clk);
		while (pending_options.size() != 0 || in_valid || expected_quotes.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_UP_FACTOR:   cfg_u = val;
			REG_DOWN_FACTOR: cfg_d = val;
			REG_UP_PROB:     cfg_q = val;
			REG_DISCOUNT:    cfg_disc = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] u, input logic [31:0] d, input logic [31:0] q,
			input logic [31:0] disc);
		write_reg(REG_UP_FACTOR, u);
		write_reg(REG_DOWN_FACTOR, d);
		write_reg(REG_UP_PROB, q);
		write_reg(REG_DISCOUNT, disc);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed options under the reset settings.
		add_option(32'h0064_0000, 32'h0064_0000, 8'd0, 1'b0, 1'b1);
		add_option(32'h0064_0000, 32'h0050_0000, 8'd0, 1'b0, 1'b1);
		add_option(32'h0000_0000, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1);
		add_option(32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 1'b0, 1'b0);
		add_option(32'hFFFF_FFFF, 32'h0000_0000, 8'd4, 1'b1, 1'b1);
		add_option(32'h0064_0000, 32'h0070_0000, 8'd128, 1'b1, 1'b1);
		drain();

		// Typical market settings with small drift.
		set_regs(32'h4147_AE14, 32'h3EBE_3DE0, 32'h4100_0000, 32'h7FF0_0000);
		no_idle = 1;
		add_option(32'h0064_0000, 32'h0064_0000, 8'd10, 1'b0, 1'b0);
		add_option(32'h0064_0000, 32'h0064_0000, 8'd10, 1'b1, 1'b1);
		add_option(32'h0064_0000, 32'h0078_0000, 8'd255, 1'b1, 1'b1);
		add_option(32'hFFFF_FFFF, 32'h0001_0000, 8'd3, 1'b0, 1'b1);
		add_option(32'h0001_0000, 32'hFFFF_FFFF, 8'd2, 1'b1, 1'b0);
		drain();
		no_idle = 0;

		// Extreme factors, zero probability and a zero discount factor.
		set_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_option(32'h0064_0000, 32'h0010_0000, 8'd5, 1'b0, 1'b1);
		add_option(32'h0064_0000, 32'h0010_0000, 8'd5, 1'b1, 1'b1);
		add_option(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd6, 1'b0, 1'b0);
		drain();

		// Probability and discount above one are clamped by the block.
		set_regs(32'h4000_0000, 32'h2000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_option(32'h0064_0000, 32'h0030_0000, 8'd7, 1'b0, 1'b1);
		add_option(32'h0064_0000, 32'h0070_0000, 8'd7, 1'b1, 1'b0);
		for (i = 0; i < 10; i++) add_random_option();
		drain();

		// Random phases under random settings.
		for (i = 0; i < 4; i++) begin
			no_idle = (i == 2);
			set_regs(32'h3C00_0000 + $urandom_range(0, 32'h0C00_0000),
				32'h3400_0000 + $urandom_range(0, 32'h0C00_0000),
				$urandom_range(0, 32'h8000_0000), $urandom_range(32'h7000_0000, 32'h8000_0000));
			repeat (18) add_random_option();
			drain();
		end
		set_regs($urandom, $urandom, $urandom, $urandom);
		repeat (10) add_random_option();
		drain();

		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_quotes.size() == 0) begin
			$display("binomial_option_pricer_tb passed");
		end else begin
			$display("binomial_option_pricer_tb failed");
		end
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#40000000;
		$display("binomial_option_pricer_tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/bop_pkg.sv
design/bop_ram.sv
design/bop_dp.sv
design/bop_ctrl.sv
design/binomial_option_pricer.sv
design/bop_checker.sv
bench/binomial_option_pricer_tb.sv
